@@ design/timed_task_scheduler_top_assert.svh @@
// Assertion macros for the timed task scheduler.
`ifndef TIMED_TASK_SCHEDULER_TOP_ASSERT_SVH
`define TIMED_TASK_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTH
`define TTS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TTS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TTS_ASSERT_IMP(label, clk, rst_n, a, c)
`define TTS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ design/tts_pkg.sv @@
`default_nettype none
package tts_pkg;
    localparam int SLOTS = 8;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_STEP = 3'd1;
    localparam logic [2:0] MODE_ADD = 3'd2;
    localparam logic [2:0] MODE_ADD_ONCE = 3'd3;
    localparam logic [2:0] MODE_KILL_ID = 3'd4;
    localparam logic [2:0] MODE_KILL_CUR = 3'd5;
    localparam logic [2:0] MODE_REPLACE = 3'd6;
    localparam logic [2:0] MODE_FIND = 3'd7;

    localparam logic [2:0] ST_READY = 3'd0;
    localparam logic [2:0] ST_TIMING = 3'd2;
    localparam logic [2:0] ST_TIMING_READY = 3'd3;
    localparam logic [2:0] ST_TIMING_ONCE = 3'd4;
    localparam logic [2:0] ST_RUN_ONCE = 3'd5;
    localparam logic [2:0] ST_KILLED = 3'd6;

    // One slot record as stored in the slot memory.
    typedef struct packed {
        logic [7:0] id;
        logic [2:0] status;
        logic [15:0] reload;
        logic [15:0] countdown;
    } t_slot;

    // Memory access between the sequencer and the slot memory.
    typedef struct packed {
        logic re;
        logic [SW-1:0] raddr;
        logic we;
        logic [SW-1:0] waddr;
        t_slot wdata;
    } t_mem_req;
endpackage
`default_nettype wire

@@ design/tts_slot_mem.sv @@
`default_nettype none
// Slot memory: one write port and one read port, read data registered.
module tts_slot_mem (
    input wire logic i_clk,
    input wire tts_pkg::t_mem_req i_req,
    output tts_pkg::t_slot o_rdata
);
    tts_pkg::t_slot r_mem [tts_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end
endmodule
`default_nettype wire

@@ design/tts_seq.sv @@
`default_nettype none
// Sequencer: walks the slot memory entry by entry for each request and takes no new request while busy.
module tts_seq (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic [2:0] i_mode,
    input wire logic [7:0] i_task_id,
    input wire logic [2:0] i_task_status,
    input wire logic [15:0] i_reload_value,
    input wire logic [15:0] i_start_count,
    input wire logic i_kill_request,
    input wire tts_pkg::t_slot i_rdata,
    output tts_pkg::t_mem_req o_req,
    output logic o_busy,
    output logic o_done,
    output logic o_dispatch_valid,
    output logic [7:0] o_dispatch_id,
    output logic o_table_full,
    output logic o_found,
    output logic [2:0] o_found_status,
    output logic [tts_pkg::CW-1:0] o_used_cnt
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TIMER = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PROC = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_SEARCH = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [tts_pkg::SW-1:0] LAST = tts_pkg::SW'(tts_pkg::SLOTS - 1);

    logic [2:0] r_state, n_state;
    logic [tts_pkg::SLOTS-1:0] r_used, n_used;
    logic [tts_pkg::SW-1:0] r_cur, n_cur;
    logic [15:0] r_pend, n_pend;
    logic [tts_pkg::SW-1:0] r_idx, n_idx;
    logic r_rv, n_rv;
    logic [2:0] r_mode;
    logic [7:0] r_id;
    logic [2:0] r_st;
    logic [15:0] r_rel, r_cnt;
    logic r_kill;
    logic r_dv, n_dv, r_full, n_full, r_fnd, n_fnd;
    logic [7:0] r_did, n_did;
    logic [2:0] r_fst, n_fst;
    tts_pkg::t_slot w_in, w_mod;
    logic [15:0] w_dec;
    logic n_to_add;

    assign w_in = '{id: r_id, status: r_st, reload: r_rel, countdown: r_cnt};
    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_dispatch_valid = o_done & r_dv;
    assign o_dispatch_id = o_done ? r_did : 8'd0;
    assign o_table_full = o_done & r_full;
    assign o_found = o_done & r_fnd;
    assign o_found_status = o_done ? r_fst : 3'd0;
    assign o_used_cnt = tts_pkg::CW'($countones(r_used));

    // Capture the request; add once turns into add after a missed id search if not full.
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_mode <= i_mode;
            r_id <= i_task_id;
            r_st <= i_task_status;
            r_rel <= i_reload_value;
            r_cnt <= i_start_count;
            r_kill <= i_kill_request;
        end else if (n_to_add) begin
            r_mode <= tts_pkg::MODE_ADD;
        end
    end

    // Next state: at most one memory read and one write a cycle.
    always_comb begin
        n_state = r_state;
        n_used = r_used;
        n_cur = r_cur;
        n_pend = r_pend;
        n_idx = r_idx;
        n_rv = 1'b0;
        n_dv = r_dv;
        n_did = r_did;
        n_full = r_full;
        n_fnd = r_fnd;
        n_fst = r_fst;
        o_req = '0;
        w_mod = i_rdata;
        w_dec = i_rdata.countdown;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dv = 1'b0;
                    n_did = '0;
                    n_full = 1'b0;
                    n_fnd = 1'b0;
                    n_fst = '0;
                    n_idx = '0;
                    unique case (i_mode)
                        tts_pkg::MODE_TICK: begin
                            if (r_pend != 16'hFFFF) begin
                                n_pend = r_pend + 16'd1;
                            end
                            n_state = S_DONE;
                        end
                        tts_pkg::MODE_STEP: begin
                            if (r_pend == 16'd0) begin
                                n_state = S_DONE;
                            end else if (r_cur == '0) begin
                                n_state = S_TIMER;
                            end else begin
                                n_idx = r_cur;
                                n_state = S_SCAN;
                            end
                        end
                        tts_pkg::MODE_KILL_CUR: begin
                            n_idx = r_cur;
                            n_state = S_SEARCH;
                        end
                        tts_pkg::MODE_REPLACE: begin
                            o_req.we = 1'b1;
                            o_req.waddr = r_cur;
                            o_req.wdata = '{id: i_task_id, status: i_task_status,
                                reload: i_reload_value, countdown: i_start_count};
                            n_used[r_cur] = 1'b1;
                            n_state = S_DONE;
                        end
                        default: n_state = S_SEARCH;
                    endcase
                end
            end
            S_TIMER: begin
                // Read slot idx, then write it back once the read data has landed.
                if (!r_rv) begin
                    o_req.re = 1'b1;
                    o_req.raddr = r_idx;
                    n_rv = 1'b1;
                end else begin
                    if (r_used[r_idx] && (i_rdata.status == tts_pkg::ST_TIMING
                            || i_rdata.status == tts_pkg::ST_TIMING_ONCE)) begin
                        if (i_rdata.countdown != 16'd0) begin
                            w_dec = i_rdata.countdown - 16'd1;
                        end
                        w_mod.countdown = w_dec;
                        if (w_dec == 16'd0) begin
                            w_mod.status = (i_rdata.status == tts_pkg::ST_TIMING)
                                ? tts_pkg::ST_TIMING_READY : tts_pkg::ST_RUN_ONCE;
                        end
                        o_req.we = 1'b1;
                        o_req.waddr = r_idx;
                        o_req.wdata = w_mod;
                    end
                    if (r_idx == LAST) begin
                        n_idx = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (r_used[r_idx]) begin
                    n_cur = r_idx;
                    o_req.re = 1'b1;
                    o_req.raddr = r_idx;
                    n_state = S_PROC;
                end else if (r_idx == LAST) begin
                    n_cur = '0;
                    n_pend = r_pend - 16'd1;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PROC: begin
                if (i_rdata.status == tts_pkg::ST_READY
                        || i_rdata.status == tts_pkg::ST_RUN_ONCE
                        || i_rdata.status == tts_pkg::ST_TIMING_READY) begin
                    n_dv = 1'b1;
                    n_did = i_rdata.id;
                    if (r_kill) begin
                        w_mod.status = tts_pkg::ST_KILLED;
                    end
                end
                if (w_mod.status == tts_pkg::ST_RUN_ONCE
                        || w_mod.status == tts_pkg::ST_KILLED) begin
                    n_idx = r_cur;
                    n_state = S_SHIFT;
                end else begin
                    if (w_mod.status == tts_pkg::ST_TIMING_READY) begin
                        w_mod.status = tts_pkg::ST_TIMING;
                        w_mod.countdown = i_rdata.reload;
                        o_req.we = 1'b1;
                        o_req.waddr = r_cur;
                        o_req.wdata = w_mod;
                    end
                    if (r_cur == LAST) begin
                        n_cur = '0;
                        n_pend = r_pend - 16'd1;
                    end else begin
                        n_cur = r_cur + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // Move later used slots up: read idx+1, then write it to idx.
                if (!r_rv) begin
                    if (r_idx != LAST && r_used[r_idx + 1'b1]) begin
                        o_req.re = 1'b1;
                        o_req.raddr = r_idx + 1'b1;
                        n_rv = 1'b1;
                    end else begin
                        n_used[r_idx] = 1'b0;
                        n_state = S_DONE;
                    end
                end else begin
                    o_req.we = 1'b1;
                    o_req.waddr = r_idx;
                    o_req.wdata = i_rdata;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SEARCH: begin
                if (!r_rv) begin
                    o_req.re = 1'b1;
                    o_req.raddr = r_idx;
                    n_rv = 1'b1;
                end else begin
                    unique case (r_mode)
                        tts_pkg::MODE_KILL_CUR: begin
                            w_mod.status = tts_pkg::ST_KILLED;
                            o_req.we = 1'b1;
                            o_req.waddr = r_idx;
                            o_req.wdata = w_mod;
                            n_state = S_DONE;
                        end
                        tts_pkg::MODE_ADD: begin
                            if (!r_used[r_idx]) begin
                                o_req.we = 1'b1;
                                o_req.waddr = r_idx;
                                o_req.wdata = w_in;
                                n_used[r_idx] = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        tts_pkg::MODE_ADD_ONCE: begin
                            if (r_used[r_idx] && i_rdata.id == r_id) begin
                                o_req.we = 1'b1;
                                o_req.waddr = r_idx;
                                o_req.wdata = w_in;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            if (r_used[r_idx] && i_rdata.id == r_id) begin
                                n_fnd = 1'b1;
                                if (r_mode == tts_pkg::MODE_FIND) begin
                                    n_fst = i_rdata.status;
                                end else begin
                                    w_mod.status = tts_pkg::ST_KILLED;
                                    o_req.we = 1'b1;
                                    o_req.waddr = r_idx;
                                    o_req.wdata = w_mod;
                                end
                                n_state = S_DONE;
                            end
                        end
                    endcase
                    if (n_state != S_DONE) begin
                        if (r_idx == LAST) begin
                            n_idx = '0;
                            if (r_mode == tts_pkg::MODE_ADD_ONCE) begin
                                // No match by id: fall back to the first free slot.
                                if (o_used_cnt == tts_pkg::CW'(tts_pkg::SLOTS)) begin
                                    n_full = 1'b1;
                                    n_state = S_DONE;
                                end else begin
                                    n_state = S_SEARCH;
                                end
                            end else begin
                                n_full = (r_mode == tts_pkg::MODE_ADD);
                                n_state = S_DONE;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Add once turns into add after a missed id search if the table is not full.
    assign n_to_add = (r_state == S_SEARCH) && r_rv && (r_idx == LAST)
        && (r_mode == tts_pkg::MODE_ADD_ONCE) && (n_state == S_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_cur <= '0;
            r_pend <= '0;
            r_idx <= '0;
            r_rv <= 1'b0;
            r_dv <= 1'b0;
            r_did <= '0;
            r_full <= 1'b0;
            r_fnd <= 1'b0;
            r_fst <= '0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_cur <= n_cur;
            r_pend <= n_pend;
            r_idx <= n_idx;
            r_rv <= n_rv;
            r_dv <= n_dv;
            r_did <= n_did;
            r_full <= n_full;
            r_fnd <= n_fnd;
            r_fst <= n_fst;
        end
    end
endmodule
`default_nettype wire

@@ design/timed_task_scheduler_top.sv @@
`default_nettype none
// Timed task scheduler. One request at a time; busy stays high through the result
// strobe. Tick and replace go straight to the result; a step from slot zero
// first runs a timer pass, then scans and may compact; add once searches by id,
// then on a miss for a free slot. A new request is taken in the cycle after the result.
// Synchronous active-low reset empties the table and clears the pending tick count.
module timed_task_scheduler_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    output logic busy,
    input wire logic [2:0] i_mode,
    input wire logic [7:0] i_task_id,
    input wire logic [2:0] i_task_status,
    input wire logic [15:0] i_reload_value,
    input wire logic [15:0] i_start_count,
    input wire logic i_kill_request,
    output logic o_valid,
    output logic o_dispatch_valid,
    output logic [7:0] o_dispatch_id,
    output logic o_table_full,
    output logic o_found,
    output logic [2:0] o_found_status
);
    tts_pkg::t_mem_req w_req;
    tts_pkg::t_slot w_rdata;
    logic [tts_pkg::CW-1:0] w_used_cnt;

    tts_slot_mem u_mem (
        .i_clk(i_clk),
        .i_req(w_req),
        .o_rdata(w_rdata)
    );

    tts_seq u_seq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_mode(i_mode),
        .i_task_id(i_task_id),
        .i_task_status(i_task_status),
        .i_reload_value(i_reload_value),
        .i_start_count(i_start_count),
        .i_kill_request(i_kill_request),
        .i_rdata(w_rdata),
        .o_req(w_req),
        .o_busy(busy),
        .o_done(o_valid),
        .o_dispatch_valid(o_dispatch_valid),
        .o_dispatch_id(o_dispatch_id),
        .o_table_full(o_table_full),
        .o_found(o_found),
        .o_found_status(o_found_status),
        .o_used_cnt(w_used_cnt)
    );

`include "timed_task_scheduler_top_assert.svh"
    `TTS_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_valid, !busy)
    `TTS_ASSERT_IMP(a_flags_only_done, i_clk, i_rst_n, !o_valid, !o_dispatch_valid && !o_found)
    `TTS_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, w_used_cnt <= tts_pkg::CW'(tts_pkg::SLOTS))
    `TTS_ASSERT_IMP(a_no_double_port, i_clk, i_rst_n, w_req.we && o_valid, !w_req.re)
endmodule
`default_nettype wire

@@ sim/timed_task_scheduler_top_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module timed_task_scheduler_top_tb;

    // Statuses that the package does not name.
    localparam logic [2:0] ST_BLOCKED = 3'd1;
    localparam logic [2:0] ST_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_REQUESTS = 400;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] id;
        logic [2:0] status;
        logic [15:0] reload;
        logic [15:0] count;
        logic kill;
    } t_sched_req;

    typedef struct packed {
        logic dv;
        logic [7:0] did;
        logic full;
        logic fnd;
        logic [2:0] fst;
    } t_sched_res;

    // A directed row: the request, and a typed-in answer where one is given.
    typedef struct packed {
        t_sched_req req;
        logic known;
        t_sched_res res;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_mode = '0;
    logic [7:0] i_task_id = '0;
    logic [2:0] i_task_status = '0;
    logic [15:0] i_reload_value = '0;
    logic [15:0] i_start_count = '0;
    logic i_kill_request = 1'b0;
    logic o_valid;
    logic o_dispatch_valid;
    logic [7:0] o_dispatch_id;
    logic o_table_full;
    logic o_found;
    logic [2:0] o_found_status;

    timed_task_scheduler_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_task_id(i_task_id),
        .i_task_status(i_task_status),
        .i_reload_value(i_reload_value),
        .i_start_count(i_start_count),
        .i_kill_request(i_kill_request),
        .o_valid(o_valid),
        .o_dispatch_valid(o_dispatch_valid),
        .o_dispatch_id(o_dispatch_id),
        .o_table_full(o_table_full),
        .o_found(o_found),
        .o_found_status(o_found_status)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the task table.
    logic tab_used [tts_pkg::SLOTS];
    logic [7:0] tab_id [tts_pkg::SLOTS];
    logic [2:0] tab_status [tts_pkg::SLOTS];
    logic [15:0] tab_reload [tts_pkg::SLOTS];
    logic [15:0] tab_count [tts_pkg::SLOTS];
    int cur_slot;
    logic [15:0] ticks_pending;

    t_sched_res expected_q[$];
    t_sched_res typed_answer;
    logic typed_valid = 1'b0;
    int errors = 0;
    int cycles = 0;
    int dispatches = 0;
    int requests = 0;
    int sender_idle_pct = 0;

    function automatic int slot_of_id(logic [7:0] id);
        for (int i = 0; i < tts_pkg::SLOTS; i++)
            if (tab_used[i] && tab_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < tts_pkg::SLOTS; i++)
            if (!tab_used[i]) return i;
        return -1;
    endfunction

    task automatic store_slot(int s, t_sched_req r);
        tab_used[s] = 1'b1;
        tab_id[s] = r.id;
        tab_status[s] = r.status;
        tab_reload[s] = r.reload;
        tab_count[s] = r.count;
    endtask

    // Predict the answer to one request and update the shadow table.
    task automatic schedule_predict(input t_sched_req r, output t_sched_res o);
        int s;
        int j;
        logic [2:0] st;
        logic swept;
        o = '0;
        swept = 1'b0;
        case (r.mode)
            tts_pkg::MODE_TICK: begin
                if (ticks_pending != 16'hFFFF) ticks_pending++;
            end
            tts_pkg::MODE_STEP: begin
                if (ticks_pending != 0) begin
                    // A step starting at slot zero first runs the timers.
                    if (cur_slot == 0) begin
                        for (int i = 0; i < tts_pkg::SLOTS; i++) begin
                            if (tab_used[i] && (tab_status[i] == tts_pkg::ST_TIMING ||
                                    tab_status[i] == tts_pkg::ST_TIMING_ONCE)) begin
                                if (tab_count[i] != 0) tab_count[i]--;
                                if (tab_count[i] == 0)
                                    tab_status[i] = (tab_status[i] == tts_pkg::ST_TIMING) ?
                                        tts_pkg::ST_TIMING_READY : tts_pkg::ST_RUN_ONCE;
                            end
                        end
                    end
                    while (!tab_used[cur_slot] && !swept) begin
                        cur_slot++;
                        if (cur_slot >= tts_pkg::SLOTS) begin
                            cur_slot = 0;
                            ticks_pending--;
                            swept = 1'b1;
                        end
                    end
                    if (!swept) begin
                        st = tab_status[cur_slot];
                        if (st == tts_pkg::ST_READY || st == tts_pkg::ST_RUN_ONCE ||
                                st == tts_pkg::ST_TIMING_READY) begin
                            o.dv = 1'b1;
                            o.did = tab_id[cur_slot];
                            if (r.kill) tab_status[cur_slot] = tts_pkg::ST_KILLED;
                        end
                        st = tab_status[cur_slot];
                        if (st == tts_pkg::ST_RUN_ONCE || st == tts_pkg::ST_KILLED) begin
                            // Close the gap by moving later used slots up.
                            j = cur_slot;
                            while (j + 1 < tts_pkg::SLOTS && tab_used[j+1]) begin
                                tab_used[j] = tab_used[j+1];
                                tab_id[j] = tab_id[j+1];
                                tab_status[j] = tab_status[j+1];
                                tab_reload[j] = tab_reload[j+1];
                                tab_count[j] = tab_count[j+1];
                                j++;
                            end
                            tab_used[j] = 1'b0;
                        end else begin
                            if (st == tts_pkg::ST_TIMING_READY) begin
                                tab_status[cur_slot] = tts_pkg::ST_TIMING;
                                tab_count[cur_slot] = tab_reload[cur_slot];
                            end
                            cur_slot++;
                            if (cur_slot >= tts_pkg::SLOTS) begin
                                cur_slot = 0;
                                if (ticks_pending != 0) ticks_pending--;
                            end
                        end
                    end
                end
            end
            tts_pkg::MODE_ADD, tts_pkg::MODE_ADD_ONCE: begin
                s = (r.mode == tts_pkg::MODE_ADD_ONCE) ? slot_of_id(r.id) : -1;
                if (s < 0) s = free_slot();
                if (s < 0) o.full = 1'b1;
                else store_slot(s, r);
            end
            tts_pkg::MODE_KILL_ID: begin
                s = slot_of_id(r.id);
                if (s >= 0) begin
                    tab_status[s] = tts_pkg::ST_KILLED;
                    o.fnd = 1'b1;
                end
            end
            tts_pkg::MODE_KILL_CUR: tab_status[cur_slot] = tts_pkg::ST_KILLED;
            tts_pkg::MODE_REPLACE: store_slot(cur_slot, r);
            default: begin
                s = slot_of_id(r.id);
                if (s >= 0) begin
                    o.fnd = 1'b1;
                    o.fst = tab_status[s];
                end
            end
        endcase
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Accept requests and record what each one should return.
    always @(posedge i_clk) begin
        t_sched_req r;
        t_sched_res p;
        if (i_rst_n && start && !busy) begin
            r = '{i_mode, i_task_id, i_task_status, i_reload_value, i_start_count,
                  i_kill_request};
            schedule_predict(r, p);
            expected_q.push_back(typed_valid ? typed_answer : p);
            requests++;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_sched_res e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_dispatch_valid) dispatches++;
                if (o_dispatch_valid !== e.dv) begin
                    $display("%0t: dispatch_valid exp %0d got %0d", $time, e.dv, o_dispatch_valid);
                    errors++;
                end
                if (o_dispatch_id !== e.did) begin
                    $display("%0t: dispatch_id exp %0d got %0d", $time, e.did, o_dispatch_id);
                    errors++;
                end
                if (o_table_full !== e.full) begin
                    $display("%0t: table_full exp %0d got %0d", $time, e.full, o_table_full);
                    errors++;
                end
                if (o_found !== e.fnd) begin
                    $display("%0t: found exp %0d got %0d", $time, e.fnd, o_found);
                    errors++;
                end
                if (o_found_status !== e.fst) begin
                    $display("%0t: found_status exp %0d got %0d", $time, e.fst, o_found_status);
                    errors++;
                end
            end
        end
    end

    // Present one request and hold it until it is taken, then at random idle a while.
    task automatic issue(input t_sched_req r, input logic known, input t_sched_res ans);
        int gap;
        i_mode <= r.mode;
        i_task_id <= r.id;
        i_task_status <= r.status;
        i_reload_value <= r.reload;
        i_start_count <= r.count;
        i_kill_request <= r.kill;
        typed_valid <= known;
        typed_answer <= ans;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_vector row(logic [2:0] m, logic [7:0] id, logic [2:0] st,
                                    logic [15:0] rl, logic [15:0] cn, logic k,
                                    logic known, t_sched_res ans);
        t_vector v;
        v.req = '{m, id, st, rl, cn, k};
        v.known = known;
        v.res = ans;
        return v;
    endfunction

    function automatic t_sched_req random_request();
        t_sched_req r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) r.mode = tts_pkg::MODE_TICK;
        else if (pick < 50) r.mode = tts_pkg::MODE_STEP;
        else if (pick < 65) r.mode = tts_pkg::MODE_ADD;
        else if (pick < 75) r.mode = tts_pkg::MODE_ADD_ONCE;
        else if (pick < 83) r.mode = tts_pkg::MODE_KILL_ID;
        else if (pick < 88) r.mode = tts_pkg::MODE_KILL_CUR;
        else if (pick < 93) r.mode = tts_pkg::MODE_REPLACE;
        else r.mode = tts_pkg::MODE_FIND;
        // Small ids collide often; sometimes any id.
        r.id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        r.status = 3'($urandom_range(7));
        r.reload = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        r.count = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        r.kill = ($urandom_range(7) == 0);
        return r;
    endfunction

    t_vector directed [$];
    t_sched_res none;

    initial begin
        t_sched_res ans;
        none = '0;
        for (int i = 0; i < tts_pkg::SLOTS; i++) begin
            tab_used[i] = 1'b0;
            tab_id[i] = '0;
            tab_status[i] = '0;
            tab_reload[i] = '0;
            tab_count[i] = '0;
        end
        cur_slot = 0;
        ticks_pending = '0;

        // Empty table after reset, then every status and the field extremes.
        directed.push_back(row(tts_pkg::MODE_STEP, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b1, none));
        directed.push_back(row(tts_pkg::MODE_FIND, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b1, none));
        directed.push_back(row(tts_pkg::MODE_KILL_ID, 8'd255, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b1, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd255, tts_pkg::ST_TIMING, 16'hFFFF, 16'd1,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD_ONCE, 8'd255, tts_pkg::ST_TIMING_ONCE, 16'd3,
                               16'd2, 1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd10, tts_pkg::ST_RUN_ONCE, 16'd0, 16'hFFFF,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd11, ST_SPARE, 16'd5, 16'd5,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd12, tts_pkg::ST_TIMING_READY, 16'd2, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd13, ST_BLOCKED, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd14, tts_pkg::ST_KILLED, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd15, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        ans = '0;
        ans.full = 1'b1;
        directed.push_back(row(tts_pkg::MODE_ADD, 8'd16, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b1, ans));
        directed.push_back(row(tts_pkg::MODE_FIND, 8'd255, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_TICK, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_TICK, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_STEP, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b1, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_STEP, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_STEP, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_KILL_CUR, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_STEP, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b1, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_KILL_ID, 8'd13, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_REPLACE, 8'd200, tts_pkg::ST_RUN_ONCE, 16'hFFFF,
                               16'hFFFF, 1'b1, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_STEP, 8'd0, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));
        directed.push_back(row(tts_pkg::MODE_FIND, 8'd200, tts_pkg::ST_READY, 16'd0, 16'd0,
                               1'b0, 1'b0, none));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) issue(directed[i].req, directed[i].known, directed[i].res);

        // Random traffic under each sender pacing, with a full drain in between.
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 8 : 0;
            for (int n = 0; n < RANDOM_REQUESTS / 4; n++) issue(random_request(), 1'b0, none);
            start <= 1'b0;
            while (expected_q.size() != 0) @(posedge i_clk);
            @(posedge i_clk);
        end

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4 * tts_pkg::SLOTS + 10) @(posedge i_clk);

        $display("Ran %0d requests (directed table, then random traffic over four pacings);",
                 requests);
        $display("%0d tasks dispatched, %0d mismatches.", dispatches, errors);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ timed_task_scheduler_top.f @@
+incdir+design
design/tts_pkg.sv
design/tts_slot_mem.sv
design/tts_seq.sv
design/timed_task_scheduler_top.sv
sim/timed_task_scheduler_top_tb.sv
